[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the direction deviation edge test.
// Depends on nothing; users supply clk_i and rst_ni in their own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define DDE_ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error(msg);
`else
`define DDE_ASSERT(label, prop, msg)
`define DDE_ASSERT_NEVER(label, prop, msg)
`endif

`endif

[sv/dde_pkg.sv]
// Types, constants and angle helpers for the direction deviation edge test.
// Depends on nothing; used by the channel interfaces and the top level.
package dde_pkg;

  localparam int unsigned AngleW = 16;

  typedef logic [AngleW-1:0] angle_t;

  // Half a turn in binary angle units.
  localparam angle_t HalfTurn = angle_t'(32768);

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // Least circular distance between two binary angles, 0 to a half turn.
  function automatic angle_t circ_dist(angle_t a, angle_t b);
    angle_t diff;
    diff = a - b;
    if (diff > HalfTurn) begin
      return angle_t'(0) - diff;
    end
    return diff;
  endfunction

endpackage

[sv/dde_if.sv]
// Valid/ready channel interfaces of the direction deviation edge test.
// Depends on dde_pkg for the angle type.

// Input request: one segment and chord pair.
interface dde_in_if;
  logic           valid;
  logic           ready;
  logic           start_new_origin;
  dde_pkg::angle_t segment_direction;
  dde_pkg::angle_t chord_direction;

  modport source (output valid, start_new_origin, segment_direction, chord_direction,
                  input ready);
  modport sink   (input valid, start_new_origin, segment_direction, chord_direction,
                  output ready);
endinterface

// Result request: deviation and flags.
interface dde_out_if;
  logic           valid;
  logic           ready;
  dde_pkg::angle_t deviation;
  logic           within_limit;
  logic           store_overflow;

  modport source (output valid, deviation, within_limit, store_overflow, input ready);
  modport sink   (input valid, deviation, within_limit, store_overflow, output ready);
endinterface

// Configuration write request for the error limit.
interface dde_cfg_if;
  logic           valid;
  logic           ready;
  dde_pkg::angle_t error_limit;

  modport source (output valid, error_limit, input ready);
  modport sink   (input valid, error_limit, output ready);
endinterface

[sv/direction_deviation_edge_test.sv]
// Top level of the direction deviation edge test: direction store and scan sequencer.
// Depends on dde_pkg, the channel interfaces in dde_if.sv and assert_macros.svh.
// Usage:
//   in_i carries one request per edge test: an optional clear of the direction
//   set, the newest segment direction and the chord direction. out_o returns one
//   result per request: the deviation of the reversed chord from the nearest
//   stored direction, a within-limit flag and a store overflow flag. cfg_i writes
//   the error limit; it is always ready, and the user must write it only while idle.
// Scan and request order:
//   The scan reads every stored direction once through the single read port,
//   one entry a cycle. The result is loaded into the output register from the
//   finish step, and only then does the sequencer return to idle and take the
//   next request, so one request is handled at a time. The block itself does
//   not enforce the idle-only rule for cfg_i writes of the error limit.
// Reset:
//   Reset empties the direction set and sets the limit to a half turn. The
//   memory is not cleared; only entries below the count are read.
// Stalls:
//   A finished result waits in the output register; a further result waits in
//   the sequencer until the register is free, holding off new requests.
`include "assert_macros.svh"

module direction_deviation_edge_test #(
  parameter int unsigned MAX_DIRECTIONS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  dde_in_if.sink    in_i,
  dde_out_if.source out_o,
  dde_cfg_if.sink   cfg_i
);
  import dde_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_DIRECTIONS + 1);
  localparam int unsigned AddrW = $clog2(MAX_DIRECTIONS);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIRECTIONS);

  // Direction memory, written at the end of a request and read during the scan.
  angle_t mem_q [MAX_DIRECTIONS];
  angle_t rd_data_q;
  logic   mem_we;

  state_e          state_q, state_d;
  logic [CntW-1:0] angle_count_q, angle_count_d;
  logic [CntW-1:0] scan_idx_q, scan_idx_d;
  logic            pend_q, pend_d;
  logic            found_q, found_d;
  angle_t          best_q, best_d;
  angle_t          seg_q, rev_q;
  angle_t          limit_q;

  logic            out_valid_q, out_valid_d;
  angle_t          dev_q;
  logic            within_q, ovf_q;

  logic            in_fire;
  logic            issue;
  logic            out_load;
  logic            append;
  logic            overflow;
  angle_t          scan_dist;
  angle_t          seg_dist;
  angle_t          best_fin;
  angle_t          dev_fin;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Scan issues a read while entries remain below the count.
  assign issue     = (state_q == ST_SCAN) && (scan_idx_q < angle_count_q);
  assign scan_dist = circ_dist(rd_data_q, rev_q);

  // End of request: append when new and room is left, and fold in its distance.
  assign append   = !found_q && (angle_count_q < MaxCnt);
  assign overflow = !found_q && (angle_count_q == MaxCnt);
  assign seg_dist = circ_dist(seg_q, rev_q);
  assign best_fin = (append && (seg_dist < best_q)) ? seg_dist : best_q;
  assign dev_fin  = HalfTurn - best_fin;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);
  assign mem_we   = out_load && append;

  // Memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[angle_count_q[AddrW-1:0]] <= seg_q;
    end
    rd_data_q <= mem_q[scan_idx_q[AddrW-1:0]];
  end

  // Sequencer and scan accumulation.
  always_comb begin
    state_d       = state_q;
    angle_count_d = angle_count_q;
    scan_idx_d    = scan_idx_q;
    pend_d        = 1'b0;
    found_d       = found_q;
    best_d        = best_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.start_new_origin) begin
            angle_count_d = '0;
          end
          scan_idx_d = '0;
          found_d    = 1'b0;
          best_d     = HalfTurn;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_d = issue;
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (pend_q) begin
          if (rd_data_q == seg_q) begin
            found_d = 1'b1;
          end
          if (scan_dist < best_q) begin
            best_d = scan_dist;
          end
        end
        if (!issue && !pend_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          if (append) begin
            angle_count_d = angle_count_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      angle_count_q <= '0;
      scan_idx_q    <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      limit_q       <= HalfTurn;
    end else begin
      state_q       <= state_d;
      angle_count_q <= angle_count_d;
      scan_idx_q    <= scan_idx_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
      if (cfg_i.valid) begin
        limit_q <= cfg_i.error_limit;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    best_q  <= best_d;
    if (in_fire) begin
      seg_q <= in_i.segment_direction;
      rev_q <= in_i.chord_direction + HalfTurn;
    end
    if (out_load) begin
      dev_q    <= dev_fin;
      within_q <= (dev_fin <= limit_q);
      ovf_q    <= overflow;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.deviation      = dev_q;
  assign out_o.within_limit   = within_q;
  assign out_o.store_overflow = ovf_q;

  // Checks on the sequencer and the store.
  `DDE_ASSERT(a_count_bound, angle_count_q <= MaxCnt, "direction count above store depth")
  `DDE_ASSERT(a_accept_scans, in_fire |=> (state_q == ST_SCAN), "request did not start a scan")
  `DDE_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH),
              "result appeared without a finished scan")
  `DDE_ASSERT(a_overflow_full, (out_load && overflow) |=> (angle_count_q == MaxCnt),
              "overflow flagged while the store had room")
  `DDE_ASSERT_NEVER(a_write_outside_finish, mem_we && (state_q != ST_FINISH),
                    "direction memory written outside the finish step")

endmodule

[dv/direction_deviation_edge_test_tb.sv]
// Testbench for direction_deviation_edge_test: directed table, then random origin runs.
// Depends on dde_pkg, the channel interfaces in dde_if.sv and the top level RTL.
// Every result is checked: typed rows against their table values, the rest against an in-bench model.
`timescale 1ns / 1ps

module direction_deviation_edge_test_tb;
  import dde_pkg::*;

  localparam int unsigned DirDepth = 64;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned HoldAtResult = 350;

  // One result as the block returns it.
  typedef struct packed {
    angle_t deviation;
    logic   within_limit;
    logic   store_overflow;
  } dev_result_t;

  // One directed row; a row with reps above one walks the segment by seg_step.
  typedef struct packed {
    bit          clear;
    angle_t      seg;
    angle_t      chord;
    logic [7:0]  reps;
    angle_t      seg_step;
    bit          typed;
    dev_result_t res;
  } stim_row_t;

  localparam int unsigned NumRows = 16;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // Reversed chord lands on the first direction: full deviation.
    '{1'b1, 16'h0000, 16'h8000, 8'd1, 16'h0000, 1'b1, '{16'h8000, 1'b1, 1'b0}},
    // Top extremes of both angles.
    '{1'b0, 16'hFFFF, 16'h7FFF, 8'd1, 16'h0000, 1'b1, '{16'h8000, 1'b1, 1'b0}},
    // Duplicate direction, nearest neighbor across the wrap.
    '{1'b0, 16'h0000, 16'h0000, 8'd1, 16'h0000, 1'b1, '{16'h0001, 1'b1, 1'b0}},
    // Chord equal to the only direction: zero deviation.
    '{1'b1, 16'h4000, 16'h4000, 8'd1, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{1'b0, 16'h8000, 16'h0000, 8'd1, 16'h0000, 1'b1, '{16'h8000, 1'b1, 1'b0}},
    '{1'b1, 16'h0000, 16'h0000, 8'd1, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{1'b0, 16'h0064, 16'h3039, 8'd1, 16'h0000, 1'b0, '0},
    '{1'b1, 16'h04D2, 16'hFFFF, 8'd1, 16'h0000, 1'b0, '0},
    // Fill the store with 64 distinct directions.
    '{1'b1, 16'h0100, 16'hABCD, 8'd64, 16'h0400, 1'b0, '0},
    // Full store: a new direction is dropped.
    '{1'b0, 16'h0300, 16'h8100, 8'd1, 16'h0000, 1'b1, '{16'h8000, 1'b1, 1'b1}},
    // Full store: a duplicate is not flagged.
    '{1'b0, 16'h0500, 16'h8500, 8'd1, 16'h0000, 1'b1, '{16'h8000, 1'b1, 1'b0}},
    '{1'b0, 16'hFFFF, 16'h7FFF, 8'd1, 16'h0000, 1'b0, '0},
    '{1'b1, 16'hFFFF, 16'hFFFF, 8'd1, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{1'b0, 16'h8000, 16'h0001, 8'd1, 16'h0000, 1'b0, '0},
    '{1'b1, 16'hAAAA, 16'h5555, 8'd1, 16'h0000, 1'b0, '0},
    '{1'b0, 16'h5555, 16'hAAAA, 8'd1, 16'h0000, 1'b0, '0}
  };

  // Limits for the random phases, the extremes among them.
  localparam int unsigned NumPhases = 8;
  localparam angle_t PhaseLimits [NumPhases] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h4000, 16'h8001, 16'h0000, 16'h8000
  };

  logic clk_i;
  logic rst_ni;

  dde_in_if  in_if ();
  dde_out_if out_if ();
  dde_cfg_if cfg_if ();

  direction_deviation_edge_test #(
    .MAX_DIRECTIONS(DirDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Model of the direction set and the limit register.
  angle_t      dir_set[$];
  angle_t      limit_model;
  dev_result_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  bit          tx_burst;
  bit          rx_burst;

  // Clock, 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Least circular distance, 0 to a half turn, in 17 bits.
  function automatic logic [16:0] arc_between(angle_t a, angle_t b);
    angle_t diff;
    diff = a - b;
    return (diff > 16'h8000) ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic dev_result_t predict_deviation(bit clear, angle_t seg, angle_t chord);
    dev_result_t res;
    angle_t      rev;
    logic [16:0] best;
    logic [16:0] arc_len;
    bit          seen;
    res  = '0;
    seen = 1'b0;
    if (clear) begin
      dir_set.delete();
    end
    foreach (dir_set[i]) begin
      if (dir_set[i] == seg) seen = 1'b1;
    end
    if (!seen) begin
      if (dir_set.size() < DirDepth) begin
        dir_set = {dir_set, seg};
      end else begin
        res.store_overflow = 1'b1;
      end
    end
    // Adding a half turn flips the top bit.
    rev  = chord ^ 16'h8000;
    best = 17'd32768;
    foreach (dir_set[i]) begin
      arc_len = arc_between(dir_set[i], rev);
      if (arc_len < best) best = arc_len;
    end
    res.deviation    = angle_t'(17'd32768 - best);
    res.within_limit = (res.deviation <= limit_model);
    return res;
  endfunction

  // Offers one request after a random gap and records its expected result.
  task automatic offer_request(input bit clear, input angle_t seg, input angle_t chord,
                               input bit typed, input dev_result_t typed_res);
    int unsigned gap;
    dev_result_t model_res;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.start_new_origin  <= clear;
    in_if.segment_direction <= seg;
    in_if.chord_direction   <= chord;
    do @(posedge clk_i); while (!in_if.ready);
    model_res = predict_deviation(clear, seg, chord);
    pending_results = {pending_results, (typed ? typed_res : model_res)};
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes the error limit while the block is idle.
  task automatic write_limit(input angle_t value);
    cfg_if.valid       <= 1'b1;
    cfg_if.error_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    limit_model = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Picks a chord that reaches the interesting distances from a stored direction.
  function automatic angle_t pick_chord(bit clear, angle_t seg);
    angle_t anchor;
    int     target;
    anchor = seg;
    if (!clear && dir_set.size() != 0 && $urandom_range(0, 1) == 1) begin
      anchor = dir_set[$urandom_range(0, dir_set.size() - 1)];
    end
    case ($urandom_range(0, 9))
      0, 1:    return anchor;                   // zero deviation
      2, 3:    return anchor ^ 16'h8000;        // full deviation
      4, 5: begin
        // Deviation right around the limit.
        target = int'(limit_model) + int'($urandom_range(0, 4)) - 2;
        if (target < 0) target = 0;
        if (target > 32768) target = 32768;
        return anchor + angle_t'(32768 - target) + 16'h8000;
      end
      default: return angle_t'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, and the result check.
  initial begin
    dev_result_t got;
    dev_result_t want;
    int unsigned gap;
    bit          held;
    out_if.ready = 1'b0;
    held         = 1'b0;
    rx_burst     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 10);
      if (!held && results_seen == HoldAtResult) begin
        held = 1'b1;
        gap  = HoldCycles;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = '{out_if.deviation, out_if.within_limit, out_if.store_overflow};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d with no request pending: dev %0d within %0b ovf %0b",
                   results_seen, got.deviation, got.within_limit, got.store_overflow);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.deviation !== want.deviation || got.within_limit !== want.within_limit ||
            got.store_overflow !== want.store_overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: exp dev %0d within %0b ovf %0b, got dev %0d within %0b ovf %0b",
                     results_seen, want.deviation, want.within_limit, want.store_overflow,
                     got.deviation, got.within_limit, got.store_overflow);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then random origin runs under several limits.
  initial begin
    stim_row_t   row;
    int unsigned sent;
    int unsigned run_len;
    bit          clear;
    angle_t      seg;
    angle_t      last_seg;
    angle_t      chord;
    mismatch_count = 0;
    results_seen   = 0;
    tx_burst       = 1'b0;
    limit_model    = 16'h8000;
    last_seg       = '0;
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.start_new_origin  = 1'b0;
    in_if.segment_direction = '0;
    in_if.chord_direction   = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.error_limit      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run under the reset limit of a half turn.
    for (int r = 0; r < NumRows; r++) begin
      row = DirectedRows[r];
      for (int k = 0; k < int'(row.reps); k++) begin
        offer_request(row.clear && k == 0, row.seg + angle_t'(k) * row.seg_step, row.chord,
                      row.typed, row.res);
      end
    end

    // Random phases; each limit is written with nothing in flight.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_limit((p == 4) ? angle_t'($urandom) : PhaseLimits[p]);
      sent = 0;
      while (sent < PhaseItems) begin
        // Most runs are short; a few overrun the store.
        run_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                               : $urandom_range(60, 80);
        for (int k = 0; k < int'(run_len) && sent < PhaseItems; k++) begin
          clear = (k == 0) || ($urandom_range(0, 99) == 0);
          case ($urandom_range(0, 19))
            0, 1, 2: seg = (dir_set.size() != 0) ?
                           dir_set[$urandom_range(0, dir_set.size() - 1)] : last_seg;
            3, 4, 5, 6: seg = last_seg + angle_t'($urandom_range(0, 1024)) - 16'd512;
            default: seg = angle_t'($urandom);
          endcase
          chord = pick_chord(clear, seg);
          offer_request(clear, seg, chord, 1'b0, '0);
          last_seg = seg;
          sent++;
        end
      end
    end

    // Let the last results arrive, then give the block time to misbehave.
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
